@@ hdl/brlp_pkg.sv @@
// Package for the byte range list parser: types, character codes and constants.
`default_nettype none

package brlp_pkg;

    localparam int MAX_RANGES_DEF = 16;
    localparam int RANGE_LIMIT_RST = 16;
    localparam int RES_DEPTH = 4;

    localparam int NUM_W = 63;
    localparam int CFG_W = 5;

    localparam logic [NUM_W-1:0] SAT63   = 63'h7FFF_FFFF_FFFF_FFFF;
    // Largest accumulator value that can still take a digit of 0 to 7 without
    // passing the saturation value.
    localparam logic [NUM_W-1:0] MAC_THR = 63'd922337203685477580;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic KIND_RANGE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_NUMBER = 2'd1;
    localparam logic [1:0] ST_TOO_MANY  = 2'd2;

    localparam logic REG_RANGE_LIMIT = 1'b0;

    typedef enum logic [2:0] {
        PH_SEEK_START = 3'd0,
        PH_START_DIG  = 3'd1,
        PH_SEEK_END   = 3'd2,
        PH_END_DIG    = 3'd3,
        PH_DONE       = 3'd4
    } phase_t;

    typedef struct packed {
        logic             kind;
        logic [3:0]       range_index;
        logic [NUM_W-1:0] start_offset;
        logic             start_present;
        logic [NUM_W-1:0] end_offset;
        logic             end_present;
        logic [1:0]       status;
        logic [4:0]       range_count;
        logic             last;
    } res_t;

    function automatic res_t range_res(input logic [3:0] idx, input logic [NUM_W-1:0] so,
                                       input logic sp, input logic [NUM_W-1:0] eo,
                                       input logic ep);
        res_t r;
        r               = '0;
        r.kind          = KIND_RANGE;
        r.range_index   = idx;
        r.start_offset  = so;
        r.start_present = sp;
        r.end_offset    = eo;
        r.end_present   = ep;
        return r;
    endfunction

    function automatic res_t status_res(input logic [1:0] st, input logic [4:0] cnt);
        res_t r;
        r             = '0;
        r.kind        = KIND_STATUS;
        r.status      = st;
        r.range_count = cnt;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/byte_range_list_parser.sv @@
// A result is queued at the edge that accepts its word, shown once earlier ones are taken.
// Throughput: one word per cycle while the result queue has room for two results;
// a word that gives a range and a status adds two results to the four-deep queue.
// Reset clears the parse state and the result queue and sets range_limit to 16.
// The accumulator update is one shared times-ten-plus-digit unit with a saturation compare.
`default_nettype none

module byte_range_list_parser
    import brlp_pkg::*;
#(
    parameter int MAX_RANGES = MAX_RANGES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,

    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output      logic [31:0]      prdata,
    output      logic             pready,

    input  wire logic             in_valid,
    output      logic             in_stall,
    input  wire logic [7:0]       char_code,
    input  wire logic             end_of_field,

    output      logic             out_valid,
    input  wire logic             out_stall,
    output      logic             kind,
    output      logic [3:0]       range_index,
    output      logic [NUM_W-1:0] start_offset,
    output      logic             start_present,
    output      logic [NUM_W-1:0] end_offset,
    output      logic             end_present,
    output      logic [1:0]       status,
    output      logic [4:0]       range_count,
    output      logic             last
);

    localparam int CNT_W = $clog2(MAX_RANGES + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int PTR_W = $clog2(RES_DEPTH);
    localparam int QC_W  = $clog2(RES_DEPTH + 1);

    // Configuration
    logic [CFG_W-1:0] range_limit_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_RANGE_LIMIT);
    assign prdata = (paddr[2] == REG_RANGE_LIMIT) ? {{(32-CFG_W){1'b0}}, range_limit_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_limit_reg <= CFG_W'(RANGE_LIMIT_RST);
        end
        else if (cfg_wr)
        begin
            range_limit_reg <= pwdata[CFG_W-1:0];
        end
    end

    // Parse state
    phase_t           phase_reg, phase_next;
    logic [NUM_W-1:0] start_acc_reg, start_acc_next;
    logic             start_seen_reg, start_seen_next;
    logic [NUM_W-1:0] end_acc_reg, end_acc_next;
    logic [CNT_W-1:0] done_reg, done_next;

    logic [QC_W-1:0]  qcnt_reg, qcnt_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, wr_ptr_inc;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    res_t             queue_mem [RES_DEPTH];

    logic in_acc;
    logic pop;

    assign in_stall  = (qcnt_reg > QC_W'(RES_DEPTH - 2));
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = (qcnt_reg != '0);
    assign pop       = out_valid && !out_stall;

    // Character classes
    logic       is_dig, is_term, is_comma, is_dash;
    logic [3:0] dval;

    assign is_dig   = !end_of_field && (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign dval     = is_dig ? 4'(char_code - CH_ZERO) : 4'd0;
    assign is_term  = end_of_field || (char_code == CH_CR) || (char_code == CH_LF);
    assign is_comma = !end_of_field && (char_code == CH_COMMA);
    assign is_dash  = !end_of_field && (char_code == CH_DASH);

    // Shared saturating times-ten-plus-digit unit.
    logic [NUM_W-1:0] mac_in, mac_thr, mac_out;

    assign mac_in  = (phase_reg == PH_START_DIG) ? start_acc_reg : end_acc_reg;
    assign mac_thr = MAC_THR - NUM_W'(dval > 4'd7);
    assign mac_out = (mac_in > mac_thr) ? SAT63
                   : (mac_in << 3) + (mac_in << 1) + NUM_W'(dval);

    logic [CMP_W-1:0] lim;

    assign lim = (CMP_W'(range_limit_reg) > CMP_W'(MAX_RANGES)) ? CMP_W'(MAX_RANGES)
                                                                : CMP_W'(range_limit_reg);

    // One step of the parser; res_a is the range or error that closes the current
    // range, res_b the result of examining the word again in seek start.
    res_t res_a, res_b;
    logic a_v, b_v;

    always_comb
    begin
        phase_t cur;
        logic   run;
        phase_next      = phase_reg;
        start_acc_next  = start_acc_reg;
        start_seen_next = start_seen_reg;
        end_acc_next    = end_acc_reg;
        done_next       = done_reg;
        res_a           = '0;
        res_b           = '0;
        a_v             = 1'b0;
        b_v             = 1'b0;
        cur             = phase_reg;
        run             = 1'b1;

        if (phase_reg == PH_DONE)
        begin
            run = 1'b0;
            if (end_of_field)
            begin
                phase_next      = PH_SEEK_START;
                start_acc_next  = '0;
                start_seen_next = 1'b0;
                end_acc_next    = '0;
                done_next       = '0;
            end
        end

        if (run && cur == PH_START_DIG)
        begin
            if (is_dig)
            begin
                start_acc_next = mac_out;
                run            = 1'b0;
            end
            else
            begin
                cur        = PH_SEEK_END;
                phase_next = PH_SEEK_END;
            end
        end

        if (run && cur == PH_SEEK_END)
        begin
            if (is_dig)
            begin
                end_acc_next = NUM_W'(dval);
                phase_next   = PH_END_DIG;
                run          = 1'b0;
            end
            else if (!(is_term || is_comma))
            begin
                run = 1'b0;
            end
            else if (!start_seen_reg)
            begin
                res_a = status_res(ST_NO_NUMBER, 5'(done_reg));
                a_v   = 1'b1;
                run   = 1'b0;
                if (end_of_field)
                begin
                    phase_next      = PH_SEEK_START;
                    start_acc_next  = '0;
                    start_seen_next = 1'b0;
                    end_acc_next    = '0;
                    done_next       = '0;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            else
            begin
                res_a      = range_res(4'(done_reg), start_acc_reg, 1'b1, '0, 1'b0);
                a_v        = 1'b1;
                done_next  = done_reg + CNT_W'(1);
                phase_next = PH_SEEK_START;
            end
        end
        else if (run && cur == PH_END_DIG)
        begin
            if (is_dig)
            begin
                end_acc_next = mac_out;
                run          = 1'b0;
            end
            else
            begin
                res_a      = range_res(4'(done_reg), start_acc_reg, start_seen_reg,
                                       end_acc_reg, 1'b1);
                a_v        = 1'b1;
                done_next  = done_reg + CNT_W'(1);
                phase_next = PH_SEEK_START;
            end
        end

        if (run)
        begin
            if (is_term)
            begin
                res_b = status_res(ST_OK, 5'(done_next));
                b_v   = 1'b1;
                if (end_of_field)
                begin
                    phase_next      = PH_SEEK_START;
                    start_acc_next  = '0;
                    start_seen_next = 1'b0;
                    end_acc_next    = '0;
                    done_next       = '0;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            else if (is_dig || is_dash)
            begin
                if (CMP_W'(done_next) >= lim)
                begin
                    res_b      = status_res(ST_TOO_MANY, 5'(done_next));
                    b_v        = 1'b1;
                    phase_next = PH_DONE;
                end
                else
                begin
                    start_acc_next  = NUM_W'(dval);
                    start_seen_next = is_dig;
                    end_acc_next    = '0;
                    phase_next      = is_dig ? PH_START_DIG : PH_SEEK_END;
                end
            end
        end

        res_a.last = !b_v;
        res_b.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SEEK_START;
            start_acc_reg  <= '0;
            start_seen_reg <= 1'b0;
            end_acc_reg    <= '0;
            done_reg       <= '0;
        end
        else if (in_acc)
        begin
            phase_reg      <= phase_next;
            start_acc_reg  <= start_acc_next;
            start_seen_reg <= start_seen_next;
            end_acc_reg    <= end_acc_next;
            done_reg       <= done_next;
        end
    end

    // Result queue
    logic [1:0] n_wr;

    assign n_wr        = in_acc ? ({1'b0, a_v} + {1'b0, b_v}) : 2'd0;
    assign wr_ptr_inc  = wr_ptr_reg + PTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(n_wr);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign qcnt_next   = qcnt_reg + QC_W'(n_wr) - QC_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qcnt_reg   <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            qcnt_reg   <= qcnt_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            if (a_v)
            begin
                queue_mem[wr_ptr_reg] <= res_a;
                if (b_v)
                begin
                    queue_mem[wr_ptr_inc] <= res_b;
                end
            end
            else if (b_v)
            begin
                queue_mem[wr_ptr_reg] <= res_b;
            end
        end
    end

    res_t head;

    assign head          = queue_mem[rd_ptr_reg];
    assign kind          = head.kind;
    assign range_index   = head.range_index;
    assign start_offset  = head.start_offset;
    assign start_present = head.start_present;
    assign end_offset    = head.end_offset;
    assign end_present   = head.end_present;
    assign status        = head.status;
    assign range_count   = head.range_count;
    assign last          = head.last;

endmodule

`default_nettype wire

@@ hdl/brlp_checker.sv @@
// Port-level checks on the byte range list parser, bound to the top level.
`default_nettype none

module brlp_checker
    import brlp_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             out_valid,
    input wire logic             out_stall,
    input wire logic             kind,
    input wire logic [NUM_W-1:0] start_offset,
    input wire logic             start_present,
    input wire logic [NUM_W-1:0] end_offset,
    input wire logic             end_present,
    input wire logic [1:0]       status,
    input wire logic [4:0]       range_count,
    input wire logic             last
);

    // A waiting word stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word withdrawn while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(start_offset) && $stable(end_offset)
                                   && $stable(kind) && $stable(last))
        else $error("result word changed while stalled");

    // A range always carries at least one number.
    a_range_has_number: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_RANGE |-> start_present || end_present)
        else $error("range word with neither number");

    a_range_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_RANGE |-> status == ST_OK && range_count == 5'd0)
        else $error("range word carries status fields");

    // The status word closes its input's results and carries no numbers.
    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_STATUS |-> last && !start_present && !end_present
                                            && start_offset == '0 && end_offset == '0)
        else $error("malformed status word");

endmodule

bind byte_range_list_parser brlp_checker u_brlp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .start_offset (start_offset),
    .start_present(start_present),
    .end_offset   (end_offset),
    .end_present  (end_present),
    .status       (status),
    .range_count  (range_count),
    .last         (last)
);

`default_nettype wire
